### src/drq_pkg.sv
// ----------------------------------------------------------------------------
// drq_pkg: shared definitions for the deferred release queue
// Command and status codes, default sizes and the chain control bundle.
// ----------------------------------------------------------------------------
package drq_pkg;

    localparam int DEPTH_DEF       = 32;
    localparam int HANDLE_BITS_DEF = 32;
    localparam int TAG_BITS        = 48;
    localparam int OUT_HANDLE_BITS = 32;

    typedef enum logic [1:0] {
        CMD_RETIRE = 2'd0,
        CMD_FENCE  = 2'd1,
        CMD_FLUSH  = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        STS_ACCEPTED = 2'd0,
        STS_FULL     = 2'd1,
        STS_RELEASED = 2'd2,
        STS_NOTHING  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    // Control broadcast to every cell of the chain
    typedef struct packed {
        logic load;    // write the incoming entry at the addressed cell
        logic shift;   // move every cell one place towards the head
        logic insert;  // during a shift, put the old head at the addressed cell
    } chain_ctl_t;

endpackage

### src/drq_cell.sv
// ----------------------------------------------------------------------------
// drq_cell: one storage cell of the entry chain
// Holds one entry; loads a new entry, takes its upper neighbour on a shift,
// or takes the recirculated head entry when it is the insert position.
// ----------------------------------------------------------------------------
module drq_cell #(
    parameter int INDEX       = 0,
    parameter int IDX_W       = 5,
    parameter int HANDLE_BITS = drq_pkg::HANDLE_BITS_DEF
) (
    input  logic                          clk,
    input  drq_pkg::chain_ctl_t           ctl,
    input  logic [IDX_W-1:0]              pos,
    input  logic [drq_pkg::TAG_BITS-1:0]  load_tag,
    input  logic [HANDLE_BITS-1:0]        load_handle,
    input  logic                          load_hh,
    input  logic [drq_pkg::TAG_BITS-1:0]  up_tag,
    input  logic [HANDLE_BITS-1:0]        up_handle,
    input  logic                          up_hh,
    input  logic [drq_pkg::TAG_BITS-1:0]  head_tag,
    input  logic [HANDLE_BITS-1:0]        head_handle,
    input  logic                          head_hh,
    output logic [drq_pkg::TAG_BITS-1:0]  tag,
    output logic [HANDLE_BITS-1:0]        handle,
    output logic                          hh
);

    logic [drq_pkg::TAG_BITS-1:0] tag_reg;
    logic [HANDLE_BITS-1:0]       handle_reg;
    logic                         hh_reg;
    logic                         hit;

    assign hit = (pos == IDX_W'(INDEX));

    // Payload only: contents are meaningless until written
    always_ff @(posedge clk)
    begin
        if (ctl.load && hit)
        begin
            tag_reg    <= load_tag;
            handle_reg <= load_handle;
            hh_reg     <= load_hh;
        end
        else if (ctl.shift && ctl.insert && hit)
        begin
            tag_reg    <= head_tag;
            handle_reg <= head_handle;
            hh_reg     <= head_hh;
        end
        else if (ctl.shift)
        begin
            tag_reg    <= up_tag;
            handle_reg <= up_handle;
            hh_reg     <= up_hh;
        end
    end

    assign tag    = tag_reg;
    assign handle = handle_reg;
    assign hh     = hh_reg;

endmodule

### src/drq_ctrl.sv
// ----------------------------------------------------------------------------
// drq_ctrl: command sequencer of the deferred release queue
// Accepts requests, drains the chain one entry a cycle unless the result
// register stalls, and drives it with a one-deep hold for the last flag.
// ----------------------------------------------------------------------------
module drq_ctrl #(
    parameter int DEPTH = drq_pkg::DEPTH_DEF,
    parameter int CNT_W = 6,
    parameter int IDX_W = 5
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [1:0]                          in_cmd,
    input  logic [drq_pkg::TAG_BITS-1:0]        in_frame,
    input  logic [drq_pkg::TAG_BITS-1:0]        head_tag,
    input  logic [drq_pkg::OUT_HANDLE_BITS-1:0] head_handle,
    input  logic                                head_hh,
    output drq_pkg::chain_ctl_t                 ctl,
    output logic [IDX_W-1:0]                    pos,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [1:0]                          out_status,
    output logic [drq_pkg::OUT_HANDLE_BITS-1:0] out_handle,
    output logic                                out_last
);

    drq_pkg::state_t state_reg, state_next;

    logic [CNT_W-1:0]                    count_reg, count_next;
    logic [CNT_W-1:0]                    k_reg, k_next;
    logic [CNT_W-1:0]                    w_reg, w_next;
    logic                                flush_reg, flush_next;
    logic [drq_pkg::TAG_BITS-1:0]        fence_reg, fence_next;
    logic                                held_valid_reg, held_valid_next;
    logic [drq_pkg::OUT_HANDLE_BITS-1:0] held_handle_reg, held_handle_next;
    logic                                out_valid_reg, out_valid_next;
    drq_pkg::status_t                    out_status_reg, out_status_next;
    logic [drq_pkg::OUT_HANDLE_BITS-1:0] out_handle_reg, out_handle_next;
    logic                                out_last_reg, out_last_next;

    logic             can_load;
    logic             accept;
    logic             due;
    logic [CNT_W-1:0] ins_sum;
    drq_pkg::cmd_t    cmd;

    assign can_load = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == drq_pkg::ST_IDLE) && can_load;
    assign accept   = in_valid && in_ready;
    assign cmd      = drq_pkg::cmd_t'(in_cmd);
    assign due      = flush_reg || (head_tag <= fence_reg);
    assign ins_sum  = k_reg + w_reg - CNT_W'(1);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            drq_pkg::ST_IDLE:
            begin
                if (accept && (cmd == drq_pkg::CMD_FENCE || cmd == drq_pkg::CMD_FLUSH))
                    state_next = drq_pkg::ST_DRAIN;
            end
            drq_pkg::ST_DRAIN:
            begin
                if (k_reg == '0)
                    state_next = drq_pkg::ST_FINISH;
            end
            drq_pkg::ST_FINISH:
            begin
                if (can_load)
                    state_next = drq_pkg::ST_IDLE;
            end
            default: state_next = drq_pkg::ST_IDLE;
        endcase
    end

    // Outputs and datapath
    always_comb
    begin
        count_next       = count_reg;
        k_next           = k_reg;
        w_next           = w_reg;
        flush_next       = flush_reg;
        fence_next       = fence_reg;
        held_valid_next  = held_valid_reg;
        held_handle_next = held_handle_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        out_status_next  = out_status_reg;
        out_handle_next  = out_handle_reg;
        out_last_next    = out_last_reg;
        ctl              = '0;
        pos              = '0;

        case (state_reg)
            drq_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    case (cmd)
                        drq_pkg::CMD_RETIRE:
                        begin
                            out_valid_next  = 1'b1;
                            out_handle_next = '0;
                            out_last_next   = 1'b1;
                            if (count_reg == CNT_W'(DEPTH))
                                out_status_next = drq_pkg::STS_FULL;
                            else
                            begin
                                out_status_next = drq_pkg::STS_ACCEPTED;
                                ctl.load        = 1'b1;
                                pos             = count_reg[IDX_W-1:0];
                                count_next      = count_reg + CNT_W'(1);
                            end
                        end
                        drq_pkg::CMD_FENCE, drq_pkg::CMD_FLUSH:
                        begin
                            k_next          = count_reg;
                            w_next          = '0;
                            flush_next      = (cmd == drq_pkg::CMD_FLUSH);
                            fence_next      = in_frame;
                            held_valid_next = 1'b0;
                        end
                        default:
                        begin
                            out_valid_next  = 1'b1;
                            out_status_next = drq_pkg::STS_NOTHING;
                            out_handle_next = '0;
                            out_last_next   = 1'b1;
                        end
                    endcase
                end
            end
            drq_pkg::ST_DRAIN:
            begin
                if (k_reg != '0 && can_load)
                begin
                    // Examine the head, then rotate the chain by one
                    ctl.shift = 1'b1;
                    k_next    = k_reg - CNT_W'(1);
                    if (due)
                    begin
                        if (head_hh)
                        begin
                            if (held_valid_reg)
                            begin
                                out_valid_next  = 1'b1;
                                out_status_next = drq_pkg::STS_RELEASED;
                                out_handle_next = held_handle_reg;
                                out_last_next   = 1'b0;
                            end
                            held_valid_next  = 1'b1;
                            held_handle_next = head_handle;
                        end
                    end
                    else
                    begin
                        ctl.insert = 1'b1;
                        pos        = ins_sum[IDX_W-1:0];
                        w_next     = w_reg + CNT_W'(1);
                    end
                end
            end
            drq_pkg::ST_FINISH:
            begin
                if (can_load)
                begin
                    out_valid_next  = 1'b1;
                    out_last_next   = 1'b1;
                    out_status_next = held_valid_reg ? drq_pkg::STS_RELEASED
                                                     : drq_pkg::STS_NOTHING;
                    out_handle_next = held_valid_reg ? held_handle_reg : '0;
                    held_valid_next = 1'b0;
                    count_next      = w_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= drq_pkg::ST_IDLE;
            count_reg      <= '0;
            k_reg          <= '0;
            w_reg          <= '0;
            held_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            k_reg          <= k_next;
            w_reg          <= w_next;
            held_valid_reg <= held_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        flush_reg       <= flush_next;
        fence_reg       <= fence_next;
        held_handle_reg <= held_handle_next;
        out_status_reg  <= out_status_next;
        out_handle_reg  <= out_handle_next;
        out_last_reg    <= out_last_next;
    end

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_handle = out_handle_reg;
    assign out_last   = out_last_reg;

    // Requests are only taken while no drain is in progress
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> state_reg == drq_pkg::ST_IDLE)
        else $error("request taken outside idle");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count beyond depth");

    a_drain_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == drq_pkg::ST_DRAIN |-> (k_reg + w_reg) <= CNT_W'(DEPTH))
        else $error("drain bookkeeping beyond depth");

    a_drain_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == drq_pkg::ST_DRAIN && k_reg != '0 && can_load)
        |=> k_reg == $past(k_reg) - CNT_W'(1))
        else $error("drain step did not consume the head");

    a_no_hold_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == drq_pkg::ST_IDLE |-> !held_valid_reg)
        else $error("held release left over after a drain");

endmodule

### src/deferred_release_queue.sv
// ----------------------------------------------------------------------------
// deferred_release_queue: frame-tagged deferred release queue
// Holds retired entries in arrival order in a chain of cells and releases
// their handles once the owning frame has completed.
// ----------------------------------------------------------------------------
// Usage
//   Requests enter on the s_axis group (command and has_handle in tuser,
//   frame index and handle in tdata). Results leave on the m_axis group:
//   status in tuser, released handle in tdata, tlast on the final result of
//   each request.
//   Retire: the result is in the output register in the cycle after acceptance;
//   a retire into a full queue gives a full status and stores nothing.
//   Fence / flush: after acceptance, for each stored entry the head of the
//   chain is examined and the chain shifts by one (survivors recirculate
//   behind the unexamined entries), then the drain closes; each result
//   register stall holds the drain. Releases come out one per cycle at most,
//   in arrival order.
//   One request is worked on at a time; the next is taken once the drain has
//   closed and the output register is free or being emptied.
//   Reset clears the entry count and all control; cell contents stay as they
//   are and are never read before being written.
//   When the receiver stalls the result is held in the output register and
//   the drain stops in place until it is taken.
// ----------------------------------------------------------------------------
module deferred_release_queue #(
    parameter int DEPTH       = drq_pkg::DEPTH_DEF,
    parameter int HANDLE_BITS = drq_pkg::HANDLE_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [79:0] s_axis_tdata,   // frame_index[47:0], handle[79:48]
    input  logic [2:0]  s_axis_tuser,   // command[1:0], has_handle[2]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // released_handle[31:0]
    output logic [1:0]  m_axis_tuser,   // status[1:0]
    output logic        m_axis_tlast
);

    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int HB_IN  = (HANDLE_BITS < 32) ? HANDLE_BITS : 32;
    localparam int TAG_W  = drq_pkg::TAG_BITS;
    localparam int OUT_HW = drq_pkg::OUT_HANDLE_BITS;

    drq_pkg::chain_ctl_t   ctl;
    logic [IDX_W-1:0]      pos;

    logic [TAG_W-1:0]       cell_tag    [DEPTH];
    logic [HANDLE_BITS-1:0] cell_handle [DEPTH];
    logic                   cell_hh     [DEPTH];

    logic [HANDLE_BITS-1:0] load_handle;
    logic [OUT_HW-1:0]      head_handle_out;

    // Narrow or widen the incoming handle to the stored width
    always_comb
    begin
        load_handle              = '0;
        load_handle[HB_IN-1:0]   = s_axis_tdata[48 +: HB_IN];
    end

    // Present the head handle at the result width
    always_comb
    begin
        head_handle_out            = '0;
        head_handle_out[HB_IN-1:0] = cell_handle[0][HB_IN-1:0];
    end

    // Row of cells: cell 0 is the head, each takes its upper neighbour on a shift
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [TAG_W-1:0]       up_tag;
        logic [HANDLE_BITS-1:0] up_handle;
        logic                   up_hh;

        if (i == DEPTH - 1)
        begin : g_top
            assign up_tag    = '0;
            assign up_handle = '0;
            assign up_hh     = 1'b0;
        end
        else
        begin : g_mid
            assign up_tag    = cell_tag[i+1];
            assign up_handle = cell_handle[i+1];
            assign up_hh     = cell_hh[i+1];
        end

        drq_cell #(
            .INDEX       (i),
            .IDX_W       (IDX_W),
            .HANDLE_BITS (HANDLE_BITS)
        ) u_cell (
            .clk         (clk),
            .ctl         (ctl),
            .pos         (pos),
            .load_tag    (s_axis_tdata[TAG_W-1:0]),
            .load_handle (load_handle),
            .load_hh     (s_axis_tuser[2]),
            .up_tag      (up_tag),
            .up_handle   (up_handle),
            .up_hh       (up_hh),
            .head_tag    (cell_tag[0]),
            .head_handle (cell_handle[0]),
            .head_hh     (cell_hh[0]),
            .tag         (cell_tag[i]),
            .handle      (cell_handle[i]),
            .hh          (cell_hh[i])
        );
    end

    drq_ctrl #(
        .DEPTH (DEPTH),
        .CNT_W (CNT_W),
        .IDX_W (IDX_W)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .in_cmd      (s_axis_tuser[1:0]),
        .in_frame    (s_axis_tdata[TAG_W-1:0]),
        .head_tag    (cell_tag[0]),
        .head_handle (head_handle_out),
        .head_hh     (cell_hh[0]),
        .ctl         (ctl),
        .pos         (pos),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_status  (m_axis_tuser),
        .out_handle  (m_axis_tdata),
        .out_last    (m_axis_tlast)
    );

endmodule

### dv/deferred_release_queue_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// deferred_release_queue_tb: self-checking bench for the deferred release queue
// Drives retire, fence, flush and unused-code requests into the stream input,
// mirrors the queue in a scoreboard and checks every result on the stream
// output against the mirrored release order, with random idling on both
// sides and one long stall of the result receiver.
// ----------------------------------------------------------------------------
module deferred_release_queue_tb;

    localparam int DEPTH           = drq_pkg::DEPTH_DEF;
    localparam int HANDLE_BITS     = drq_pkg::HANDLE_BITS_DEF;
    localparam logic [31:0] HANDLE_MASK =
        (HANDLE_BITS >= 32) ? 32'hFFFF_FFFF : ((32'd1 << HANDLE_BITS) - 32'd1);
    localparam logic [1:0] CMD_UNUSED = 2'd3;   // no operation, nothing released
    localparam logic [drq_pkg::TAG_BITS-1:0] TAG_MAX = '1;

    localparam int RANDOM_ITEMS    = 450;
    localparam int IDLE_PERCENT    = 11;
    localparam int CALM_FROM       = 250;       // window with no idling on either side
    localparam int CALM_TO         = 350;
    localparam int HOLD_OFF_AT     = 120;       // requests taken before the long stall
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int QUIET_LIMIT     = 4000;      // cycles with no transfer at all
    localparam int TAIL_CYCLES     = DEPTH + 16;

    // One result as the queue should produce it
    typedef struct {
        drq_pkg::status_t status;
        logic [31:0]      handle;
        logic             last;
    } release_t;

    // ------------------------------------------------------------------------
    // Scoreboard: mirror of the queue and the results still owed by the block
    // ------------------------------------------------------------------------
    class release_scoreboard;
        logic [drq_pkg::TAG_BITS-1:0] tag_q    [DEPTH];
        logic [31:0]                  handle_q [DEPTH];
        logic                         has_q    [DEPTH];
        int unsigned                  count;
        release_t                     pending_releases [$];
        int unsigned                  errors;

        function new();
            count  = 0;
            errors = 0;
        endfunction

        function int pending();
            return pending_releases.size();
        endfunction

        function void owe(drq_pkg::status_t st, logic [31:0] hnd, logic lst);
            release_t r;
            r.status = st;
            r.handle = hnd;
            r.last   = lst;
            pending_releases.insert(pending_releases.size(), r);
        endfunction

        // Update the mirror for one accepted request and queue what it owes
        function void note_request(logic [1:0] cmd, logic [drq_pkg::TAG_BITS-1:0] frame,
                                   logic [31:0] hnd, logic hh);
            logic [31:0] freed [$];
            int unsigned kept;
            kept = 0;
            if (cmd == drq_pkg::CMD_RETIRE)
            begin
                if (count >= DEPTH)
                    owe(drq_pkg::STS_FULL, '0, 1'b1);
                else
                begin
                    tag_q[count]    = frame;
                    handle_q[count] = hnd & HANDLE_MASK;
                    has_q[count]    = hh;
                    count++;
                    owe(drq_pkg::STS_ACCEPTED, '0, 1'b1);
                end
                return;
            end
            if (cmd == drq_pkg::CMD_FENCE || cmd == drq_pkg::CMD_FLUSH)
            begin
                // Release due entries in arrival order, compact survivors
                for (int r = 0; r < int'(count); r++)
                begin
                    if (cmd == drq_pkg::CMD_FLUSH || tag_q[r] <= frame)
                    begin
                        if (has_q[r])
                            freed.insert(freed.size(), handle_q[r]);
                    end
                    else
                    begin
                        tag_q[kept]    = tag_q[r];
                        handle_q[kept] = handle_q[r];
                        has_q[kept]    = has_q[r];
                        kept++;
                    end
                end
                count = kept;
            end
            // Unused code and drains that free no handle leave a single nothing-released result
            if (freed.size() == 0)
                owe(drq_pkg::STS_NOTHING, '0, 1'b1);
            foreach (freed[i])
                owe(drq_pkg::STS_RELEASED, freed[i], i == freed.size() - 1);
        endfunction

        // Compare one result with the oldest outstanding one
        function void check_result(logic [1:0] st, logic [31:0] hnd, logic lst);
            release_t want;
            if (pending_releases.size() == 0)
            begin
                $display("%0t: unexpected result: status %0d handle %h last %b",
                         $time, st, hnd, lst);
                errors++;
                return;
            end
            want = pending_releases.pop_front();
            if (st !== want.status)
            begin
                $display("%0t: status mismatch: expected %0d, actual %0d",
                         $time, want.status, st);
                errors++;
            end
            if (hnd !== want.handle)
            begin
                $display("%0t: released_handle mismatch: expected %h, actual %h",
                         $time, want.handle, hnd);
                errors++;
            end
            if (lst !== want.last)
            begin
                $display("%0t: last mismatch: expected %b, actual %b",
                         $time, want.last, lst);
                errors++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Block under test
    // ------------------------------------------------------------------------
    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [79:0] s_axis_tdata;     // frame_index[47:0], handle[79:48]
    logic [2:0]  s_axis_tuser;     // command[1:0], has_handle[2]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;     // released_handle[31:0]
    logic [1:0]  m_axis_tuser;     // status[1:0]
    logic        m_axis_tlast;

    deferred_release_queue #(
        .DEPTH       (DEPTH),
        .HANDLE_BITS (HANDLE_BITS)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    release_scoreboard sb = new();

    int sent_count     = 0;   // requests accepted, as seen by the sender
    int requests_taken = 0;   // requests accepted, as seen by the monitor
    bit send_idle_en   = 1'b1;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Monitor: note every accepted request, check every accepted result.
    // A result can never belong to a request taken at the same edge, so
    // noting first is safe.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            sb.note_request(s_axis_tuser[1:0], s_axis_tdata[47:0],
                            s_axis_tdata[79:48], s_axis_tuser[2]);
            requests_taken <= requests_taken + 1;
        end
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tuser, m_axis_tdata, m_axis_tlast);
    end

    // ------------------------------------------------------------------------
    // Result receiver: random back-pressure, a calm window, and one long
    // hold-off so that the queue backs up and stalls its input.
    // ------------------------------------------------------------------------
    initial
    begin : result_sink
        bit held;
        held = 1'b0;
        m_axis_tready = 1'b0;
        @(posedge clk);
        forever
        begin
            if (!held && requests_taken >= HOLD_OFF_AT)
            begin
                held = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end
            else
            begin
                m_axis_tready <= (requests_taken >= CALM_FROM && requests_taken < CALM_TO)
                                 || ($urandom_range(0, 99) >= IDLE_PERCENT);
                @(posedge clk);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: end the run if nothing moves on either side for too long
    // ------------------------------------------------------------------------
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Sender: optionally idle, then offer one request and hold it until taken.
    // tvalid stays high across back-to-back requests.
    // ------------------------------------------------------------------------
    task automatic send_request(input logic [1:0] cmd,
                                input logic [drq_pkg::TAG_BITS-1:0] frame,
                                input logic [31:0] hnd, input logic hh);
        while (send_idle_en && $urandom_range(0, 99) < IDLE_PERCENT)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {hnd, frame};
        s_axis_tuser  <= {hh, cmd};
        do
            @(posedge clk);
        while (!s_axis_tready);
        sent_count++;
    endtask

    // Directed part: empty drains, extreme tags and handles, entries without
    // handles, entries not yet due, compaction of survivors, the unused code
    task automatic directed_requests();
        send_request(drq_pkg::CMD_FLUSH,  '0, $urandom, 1'b1);          // flush on empty
        send_request(drq_pkg::CMD_FENCE,  '0, $urandom, 1'b0);          // fence on empty
        send_request(CMD_UNUSED, TAG_MAX, $urandom, 1'b1);              // unused code
        send_request(drq_pkg::CMD_RETIRE, '0, 32'h0000_0000, 1'b1);
        send_request(drq_pkg::CMD_RETIRE, TAG_MAX, 32'hFFFF_FFFF, 1'b1);
        send_request(drq_pkg::CMD_RETIRE, 48'd5, 32'hA5A5_A5A5, 1'b0);  // no handle
        send_request(drq_pkg::CMD_RETIRE, 48'd5, 32'h5A5A_5A5A, 1'b1);
        send_request(drq_pkg::CMD_FENCE,  48'd0, 32'h0, 1'b0);          // releases zero handle
        send_request(drq_pkg::CMD_FENCE,  48'd4, 32'h0, 1'b0);          // nothing due
        send_request(drq_pkg::CMD_RETIRE, 48'd3, 32'h1234_5678, 1'b0);
        send_request(drq_pkg::CMD_FENCE,  48'd4, 32'h0, 1'b0);          // handle-less entry due
        send_request(drq_pkg::CMD_FENCE,  48'd5, 32'h0, 1'b0);
        send_request(drq_pkg::CMD_FENCE,  TAG_MAX, 32'h0, 1'b0);        // largest frame
        send_request(drq_pkg::CMD_FENCE,  TAG_MAX, 32'h0, 1'b0);
        send_request(drq_pkg::CMD_RETIRE, 48'd7, 32'h0000_0001, 1'b1);
        send_request(drq_pkg::CMD_RETIRE, 48'd2, 32'h0000_0002, 1'b1);
        send_request(drq_pkg::CMD_RETIRE, 48'd9, 32'h0000_0003, 1'b1);
        send_request(drq_pkg::CMD_RETIRE, 48'd1, 32'h0000_0004, 1'b0);
        send_request(drq_pkg::CMD_FENCE,  48'd7, 32'h0, 1'b0);          // survivor to the front
        send_request(drq_pkg::CMD_RETIRE, 48'd8, 32'h0000_0005, 1'b1);
        send_request(drq_pkg::CMD_FENCE,  48'd8, 32'h0, 1'b0);
        send_request(drq_pkg::CMD_FLUSH,  '0, 32'h0, 1'b0);
        send_request(drq_pkg::CMD_RETIRE, 48'd0, 32'h0000_0006, 1'b0);
        send_request(drq_pkg::CMD_FLUSH,  TAG_MAX, 32'hFFFF_FFFF, 1'b1); // handle-less only
    endtask

    // Random part: mostly frame-by-frame traffic (a few retires, then a fence
    // lagging behind), with bursts that fill the queue past full, flushes,
    // the unused code and fully random requests as noise
    task automatic random_traffic();
        logic [drq_pkg::TAG_BITS-1:0] frame_now;
        int unsigned pick;
        int stop_at;
        frame_now = drq_pkg::TAG_BITS'({$urandom, $urandom});
        stop_at = sent_count + RANDOM_ITEMS;
        while (sent_count < stop_at)
        begin
            send_idle_en = !(sent_count >= CALM_FROM && sent_count < CALM_TO);
            pick = $urandom_range(0, 99);
            if (pick < 70)
            begin
                repeat ($urandom_range(0, 6))
                    send_request(drq_pkg::CMD_RETIRE, frame_now + $urandom_range(0, 3),
                                 $urandom, $urandom_range(0, 99) < 80);
                send_request(drq_pkg::CMD_FENCE, frame_now - $urandom_range(0, 3), $urandom,
                             1'($urandom_range(0, 1)));
                frame_now = frame_now + $urandom_range(1, 2);
            end
            else if (pick < 78)
            begin
                // Overfill, then drain part or all of it
                repeat (DEPTH + 2)
                    send_request(drq_pkg::CMD_RETIRE, frame_now + $urandom_range(0, 7),
                                 $urandom, 1'($urandom_range(0, 1)));
                if ($urandom_range(0, 1))
                    send_request(drq_pkg::CMD_FLUSH,
                                 drq_pkg::TAG_BITS'({$urandom, $urandom}), $urandom,
                                 1'($urandom_range(0, 1)));
                else
                    send_request(drq_pkg::CMD_FENCE, frame_now + 3, $urandom,
                                 1'($urandom_range(0, 1)));
            end
            else if (pick < 85)
                send_request(drq_pkg::CMD_FLUSH, drq_pkg::TAG_BITS'({$urandom, $urandom}),
                             $urandom, 1'($urandom_range(0, 1)));
            else if (pick < 89)
                send_request(CMD_UNUSED, drq_pkg::TAG_BITS'({$urandom, $urandom}),
                             $urandom, 1'($urandom_range(0, 1)));
            else if (pick < 92)
                frame_now = drq_pkg::TAG_BITS'({$urandom, $urandom}); // new frame range
            else
                send_request(2'($urandom_range(0, 3)),
                             drq_pkg::TAG_BITS'({$urandom, $urandom}), $urandom,
                             1'($urandom_range(0, 1)));
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_requests();
        random_traffic();
        s_axis_tvalid <= 1'b0;

        // Let the monitor see the last request, then drain what is owed
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (sb.errors == 0 && sb.pending() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
